>>> rtl/core/mst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mst_pkg
// Shared types and constants of the multitouch slot tracker.
// ----------------------------------------------------------------------------
package mst_pkg;

  // Widest slot index that the result format carries.
  localparam int SlotIdW = 4;
  localparam int DefSlots = 10;

  localparam logic [15:0] EvTypeSyn = 16'h0000;
  localparam logic [15:0] EvTypeAbs = 16'h0003;

  localparam logic [15:0] CodeReport = 16'h0000;
  localparam logic [15:0] CodeSlot   = 16'h002f;
  localparam logic [15:0] CodeTrack  = 16'h0039;
  localparam logic [15:0] CodeX      = 16'h0035;
  localparam logic [15:0] CodeY      = 16'h0036;

  localparam logic signed [31:0] NoContactId = -32'sd1;

  typedef struct packed {
    logic [15:0]        event_type;
    logic [15:0]        event_code;
    logic signed [31:0] event_value;
  } mst_event_t;

  typedef struct packed {
    logic [SlotIdW-1:0] slot_index;
    logic               contact_up;
    logic signed [31:0] contact_id;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic               last_of_report;
  } mst_result_t;

  typedef struct packed {
    logic signed [31:0] id;
    logic signed [31:0] x;
    logic signed [31:0] y;
  } mst_slot_t;

  typedef struct packed {
    logic               wr_id;
    logic               wr_x;
    logic               wr_y;
    logic [SlotIdW-1:0] wr_addr;
    logic signed [31:0] wr_value;
    logic               rd_en;
    logic [SlotIdW-1:0] rd_addr;
  } mst_mem_req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EMIT
  } mst_state_t;

endpackage

>>> rtl/core/mst_slot_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mst_slot_mem
// Slot store: id, X and Y per slot with per-field write enables and one
// registered read port. Fields never written read as their reset values.
// ----------------------------------------------------------------------------
module mst_slot_mem #(
  parameter int SLOTS = mst_pkg::DefSlots
) (
  input  logic                  clk,
  input  logic                  rst,
  input  mst_pkg::mst_mem_req_t req,
  output mst_pkg::mst_slot_t    rd_slot
);

  localparam int IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  mst_pkg::mst_slot_t mem [SLOTS];
  logic [SLOTS-1:0]   id_set;
  logic [SLOTS-1:0]   x_set;
  logic [SLOTS-1:0]   y_set;
  mst_pkg::mst_slot_t rd_raw;
  logic               rd_id_ok;
  logic               rd_x_ok;
  logic               rd_y_ok;
  logic [IdxW-1:0]    wa;
  logic [IdxW-1:0]    ra;

  assign wa = req.wr_addr[IdxW-1:0];
  assign ra = req.rd_addr[IdxW-1:0];

  always_ff @(posedge clk) begin
    if (req.wr_id) begin
      mem[wa].id <= req.wr_value;
    end
    if (req.wr_x) begin
      mem[wa].x <= req.wr_value;
    end
    if (req.wr_y) begin
      mem[wa].y <= req.wr_value;
    end
    if (req.rd_en) begin
      rd_raw   <= mem[ra];
      rd_id_ok <= id_set[ra];
      rd_x_ok  <= x_set[ra];
      rd_y_ok  <= y_set[ra];
    end
  end

  // Written flags stand in for the reset contents of the store.
  always_ff @(posedge clk) begin
    if (rst) begin
      id_set <= '0;
      x_set  <= '0;
      y_set  <= '0;
    end else begin
      if (req.wr_id) id_set[wa] <= 1'b1;
      if (req.wr_x)  x_set[wa]  <= 1'b1;
      if (req.wr_y)  y_set[wa]  <= 1'b1;
    end
  end

  always_comb begin
    rd_slot.id = rd_id_ok ? rd_raw.id : mst_pkg::NoContactId;
    rd_slot.x  = rd_x_ok  ? rd_raw.x  : '0;
    rd_slot.y  = rd_y_ok  ? rd_raw.y  : '0;
  end

endmodule

>>> rtl/core/mst_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mst_ctrl
// Event decoder and report sequencer: changed marks, current slot and the
// scan that reads changed slots back one at a time.
// ----------------------------------------------------------------------------
module mst_ctrl #(
  parameter int SLOTS = mst_pkg::DefSlots
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  mst_pkg::mst_event_t   in_data,
  input  logic                  out_free,
  output logic                  res_load,
  output mst_pkg::mst_result_t  res_data,
  output mst_pkg::mst_mem_req_t mem_req,
  input  mst_pkg::mst_slot_t    rd_slot
);

  localparam int IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  mst_pkg::mst_state_t state;
  mst_pkg::mst_state_t state_next;
  logic [SLOTS-1:0]    dirty;
  logic [IdxW-1:0]     active;
  logic [IdxW-1:0]     scan_idx;
  logic                scan_last;
  logic [IdxW-1:0]     pick;
  logic                pick_single;
  logic                acc;
  logic                is_abs;
  logic                is_report;
  logic                slot_ok;
  logic                wr_field;

  assign acc       = in_valid && in_ready;
  assign is_abs    = in_data.event_type == mst_pkg::EvTypeAbs;
  assign is_report = (in_data.event_type == mst_pkg::EvTypeSyn)
                     && (in_data.event_code == mst_pkg::CodeReport);
  assign slot_ok   = !in_data.event_value[31]
                     && ($unsigned(in_data.event_value) < 32'(SLOTS));
  assign wr_field  = is_abs && ((in_data.event_code == mst_pkg::CodeTrack)
                     || (in_data.event_code == mst_pkg::CodeX)
                     || (in_data.event_code == mst_pkg::CodeY));

  // Lowest changed slot; marks only clear during a scan, so no index is skipped.
  always_comb begin
    pick = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (dirty[i]) pick = IdxW'(i);
    end
  end

  assign pick_single = (dirty & (dirty - SLOTS'(1))) == '0;

  always_comb begin
    state_next = state;
    unique case (state)
      mst_pkg::ST_IDLE: begin
        if (acc && is_report && (dirty != '0)) state_next = mst_pkg::ST_READ;
      end
      mst_pkg::ST_READ: begin
        state_next = mst_pkg::ST_EMIT;
      end
      mst_pkg::ST_EMIT: begin
        if (out_free) state_next = scan_last ? mst_pkg::ST_IDLE : mst_pkg::ST_READ;
      end
      default: state_next = mst_pkg::ST_IDLE;
    endcase
  end

  // In idle the input is always ready, so a valid event is a transfer.
  always_comb begin
    in_ready         = 1'b0;
    res_load         = 1'b0;
    mem_req          = '0;
    mem_req.wr_addr  = mst_pkg::SlotIdW'(active);
    mem_req.wr_value = in_data.event_value;
    mem_req.rd_addr  = mst_pkg::SlotIdW'(pick);
    unique case (state)
      mst_pkg::ST_IDLE: begin
        in_ready       = 1'b1;
        mem_req.wr_id  = in_valid && is_abs && (in_data.event_code == mst_pkg::CodeTrack);
        mem_req.wr_x   = in_valid && is_abs && (in_data.event_code == mst_pkg::CodeX);
        mem_req.wr_y   = in_valid && is_abs && (in_data.event_code == mst_pkg::CodeY);
      end
      mst_pkg::ST_READ: begin
        mem_req.rd_en = 1'b1;
      end
      mst_pkg::ST_EMIT: begin
        res_load = out_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    res_data.slot_index     = mst_pkg::SlotIdW'(scan_idx);
    res_data.contact_up     = rd_slot.id[31];
    res_data.contact_id     = rd_slot.id;
    res_data.pos_x          = rd_slot.id[31] ? '0 : rd_slot.x;
    res_data.pos_y          = rd_slot.id[31] ? '0 : rd_slot.y;
    res_data.last_of_report = scan_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= mst_pkg::ST_IDLE;
      dirty  <= '0;
      active <= '0;
    end else begin
      state <= state_next;
      if (acc && wr_field) dirty[active] <= 1'b1;
      if (acc && is_abs && (in_data.event_code == mst_pkg::CodeSlot) && slot_ok) begin
        active <= in_data.event_value[IdxW-1:0];
      end
      if (res_load) dirty[scan_idx] <= 1'b0;
    end
  end

  // Hold the slot under read and whether it is the final changed one.
  always_ff @(posedge clk) begin
    if (state == mst_pkg::ST_READ) begin
      scan_idx  <= pick;
      scan_last <= pick_single;
    end
  end

endmodule

>>> rtl/core/multitouch_slot_tracker_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multitouch_slot_tracker_core
// Multitouch slot decoder (protocol type B) with a slot store in memory.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_ready / in_data) takes one touch event per
//   transfer: type, code and signed value. Output channel (out_valid /
//   out_ready / out_data) delivers one result per changed slot on a report.
//   Slot select, tracking id, X and Y events are taken while idle, and the
//   block stays ready for the next event. Other events are dropped.
//   A report with changed slots holds in_ready low while each slot is read
//   from memory (ST_READ) and then loaded into the output register once it
//   is free (ST_EMIT). With no changed slot a report leaves the block idle.
//   Results leave in ascending slot order; last_of_report marks the final
//   one. The output register can take the next result in the cycle its old
//   one transfers, so a stalled receiver simply stalls the scan.
//   Reset clears all changed marks, the current slot and the output valid
//   flag; slot fields read back as id -1 and position 0 until written.
// ----------------------------------------------------------------------------
module multitouch_slot_tracker_core #(
  parameter int SLOTS = mst_pkg::DefSlots
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mst_pkg::mst_event_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mst_pkg::mst_result_t out_data
);

  mst_pkg::mst_mem_req_t mem_req;
  mst_pkg::mst_slot_t    rd_slot;
  mst_pkg::mst_result_t  res_data;
  logic                  res_load;
  logic                  out_free;

  // Output register is free when empty or draining this cycle.
  assign out_free = !out_valid || out_ready;

  mst_ctrl #(
    .SLOTS(SLOTS)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data (in_data),
    .out_free(out_free),
    .res_load(res_load),
    .res_data(res_data),
    .mem_req (mem_req),
    .rd_slot (rd_slot)
  );

  mst_slot_mem #(
    .SLOTS(SLOTS)
  ) u_mem (
    .clk    (clk),
    .rst    (rst),
    .req    (mem_req),
    .rd_slot(rd_slot)
  );

  // Output register: advance on load, drop valid after the transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_data <= res_data;
    end
  end

`ifndef SYNTHESIS
  // A pending non-final result means the scan is still running.
  a_scan_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.last_of_report |-> !in_ready)
    else $error("input accepted while report scan in progress");

  // After a non-final result transfers, the next one is loaded or pending.
  a_scan_continues: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_data.last_of_report |=> out_valid || !in_ready)
    else $error("report scan ended without final result");

  // A lifted contact reports a zero position and a negative id.
  a_lift_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.contact_up == out_data.contact_id[31])
      && (!out_data.contact_up || ((out_data.pos_x == 0) && (out_data.pos_y == 0))))
    else $error("contact_up result fields inconsistent");
`endif

endmodule
